### rtl/core/evq_pkg.sv
// shared types, constants and decode helpers for the usb midi event queue
package evq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 256;

  localparam int unsigned EVENT_W = 24;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned FILL_W  = 8;

  // high nibble of the status byte for note messages
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

  typedef enum logic [2:0] {
    RC_IGNORED = 3'd0,
    RC_QUEUED  = 3'd1,
    RC_DROPPED = 3'd2,
    RC_POPPED  = 3'd3,
    RC_EMPTY   = 3'd4
  } result_t;

  // request stage contents handed to the result stage
  typedef struct packed {
    result_t            rc;
    logic [COUNT_W-1:0] events;
    logic [COUNT_W-1:0] overrun;
    logic [FILL_W-1:0]  fill;
  } stage_t;

  // number of midi bytes carried for a code index number
  function automatic logic [1:0] code_len(input logic [3:0] cin);
    logic [1:0] len;
    case (cin) inside
      4'h1, 4'h5, 4'hF:        len = 2'd1;
      4'h2, 4'h6, 4'hC, 4'hD:  len = 2'd2;
      4'h0:                    len = 2'd0;
      default:                 len = 2'd3;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/evq_ram.sv
// generic single write port ram with registered read
module evq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/evq_ctrl.sv
// request stage: packet decode, ring pointers, event and overrun counters
module evq_ctrl import evq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic                           advance,
  input  logic                           req_type,
  input  logic [7:0]                     header_byte,
  input  logic [7:0]                     midi_byte0,
  input  logic [7:0]                     midi_byte1,
  input  logic [7:0]                     midi_byte2,
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output logic [EVENT_W-1:0]             wr_data,
  output logic                           rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output logic                           stage_valid,
  output stage_t                         stage
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = PW + 1;

  logic [PW-1:0]      wp, wp_next, rp, rp_next, wp_inc, rp_inc;
  logic [COUNT_W-1:0] events, events_next, overrun, overrun_next;
  logic               valid, valid_next;
  stage_t             stage_next;
  logic [1:0]         len;
  logic               full, empty;
  logic [FW-1:0]      held;
  logic [FW+FILL_W-1:0] held_ext;
  result_t            rc;

  assign len    = code_len(header_byte[3:0]);
  assign wp_inc = (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc = (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign full   = (wp_inc == rp);
  assign empty  = (wp == rp);

  always_comb begin
    wp_next      = wp;
    rp_next      = rp;
    events_next  = events;
    overrun_next = overrun;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rc           = RC_IGNORED;
    if (!req_type) begin
      if (len == 2'd0) begin
        rc = RC_IGNORED;
      end else if (full) begin
        rc           = RC_DROPPED;
        events_next  = events + 1'b1;
        overrun_next = overrun + 1'b1;
      end else begin
        rc          = RC_QUEUED;
        events_next = events + 1'b1;
        wp_next     = wp_inc;
        wr_en       = take;
      end
    end else begin
      if (empty) begin
        rc = RC_EMPTY;
      end else begin
        rc      = RC_POPPED;
        rp_next = rp_inc;
        rd_en   = take;
      end
    end
  end

  assign wr_addr = wp;
  assign rd_addr = rp;
  assign wr_data = {midi_byte0,
                    (len >= 2'd2) ? midi_byte1 : 8'd0,
                    (len == 2'd3) ? midi_byte2 : 8'd0};

  // entries held after this request
  always_comb begin
    if (wp_next >= rp_next) begin
      held = {1'b0, wp_next} - {1'b0, rp_next};
    end else begin
      held = {1'b0, wp_next} + FW'(QUEUE_DEPTH) - {1'b0, rp_next};
    end
  end
  assign held_ext = {{FILL_W{1'b0}}, held};

  assign stage_next.rc      = rc;
  assign stage_next.events  = events_next;
  assign stage_next.overrun = overrun_next;
  assign stage_next.fill    = held_ext[FILL_W-1:0];

  assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      events  <= '0;
      overrun <= '0;
      valid   <= 1'b0;
    end else begin
      valid <= valid_next;
      if (take) begin
        wp      <= wp_next;
        rp      <= rp_next;
        events  <= events_next;
        overrun <= overrun_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= stage_next;
    end
  end

  assign stage_valid = valid;

endmodule

### rtl/core/evq_out.sv
// result stage: popped event fields, note counters and the output register
module evq_out import evq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               stage_valid,
  input  stage_t             stage,
  input  logic [EVENT_W-1:0] rd_data,
  output logic               out_valid,
  output result_t            result_code,
  output logic [7:0]         event_status,
  output logic [7:0]         event_data_a,
  output logic [7:0]         event_data_b,
  output logic [COUNT_W-1:0] events_seen,
  output logic [COUNT_W-1:0] note_on_total,
  output logic [COUNT_W-1:0] note_off_total,
  output logic [COUNT_W-1:0] overrun_total,
  output logic [FILL_W-1:0]  fill_level
);

  logic [COUNT_W-1:0] note_on, note_on_next, note_off, note_off_next;
  logic               popped, load, is_on, is_off;
  logic [3:0]         cmd;
  logic               valid;

  assign popped = (stage.rc == RC_POPPED);
  assign load   = advance && stage_valid;
  assign cmd    = rd_data[23:20];
  assign is_on  = (cmd == CMD_NOTE_ON) && (rd_data[7:0] != 8'd0);
  assign is_off = !is_on && ((cmd == CMD_NOTE_OFF) || (cmd == CMD_NOTE_ON));

  assign note_on_next  = (popped && is_on)  ? note_on + 1'b1  : note_on;
  assign note_off_next = (popped && is_off) ? note_off + 1'b1 : note_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_on  <= '0;
      note_off <= '0;
      valid    <= 1'b0;
    end else begin
      if (advance) begin
        valid <= stage_valid;
      end
      if (load) begin
        note_on  <= note_on_next;
        note_off <= note_off_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_code    <= stage.rc;
      event_status   <= popped ? rd_data[23:16] : 8'd0;
      event_data_a   <= popped ? rd_data[15:8]  : 8'd0;
      event_data_b   <= popped ? rd_data[7:0]   : 8'd0;
      events_seen    <= stage.events;
      note_on_total  <= note_on_next;
      note_off_total <= note_off_next;
      overrun_total  <= stage.overrun;
      fill_level     <= stage.fill;
    end
  end

  assign out_valid = valid;

endmodule

### rtl/core/usb_midi_event_queue.sv
// top level of the usb midi event packet queue
// a request is registered in the request stage, then in the result stage output register
// throughput: one request per cycle, set by the single write and single read port of the event ram
// a waiting result holds both stages; only an empty request stage takes one more request
// reset clears the ring pointers, all counters and the stage valids
// the event ram is not cleared; a pop only ever reads an entry written by an earlier push
module usb_midi_event_queue import evq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // request side
  input  logic         s_tvalid,
  output logic         s_tready,
  // header_byte [7:0], midi_byte0 [15:8], midi_byte1 [23:16], midi_byte2 [31:24]
  input  logic [31:0]  s_tdata,
  // req_type [0]
  input  logic [0:0]   s_tuser,
  // result side
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_status [7:0], event_data_a [15:8], event_data_b [23:16], events_seen [55:24],
  // note_on_total [87:56], note_off_total [119:88], overrun_total [151:120],
  // fill_level [159:152]
  output logic [159:0] m_tdata,
  // result_code [2:0]
  output logic [2:0]   m_tuser
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic               take, advance;
  logic               wr_en, rd_en;
  logic [PW-1:0]      wr_addr, rd_addr;
  logic [EVENT_W-1:0] wr_data, rd_data;
  logic               stage_valid;
  stage_t             stage;
  result_t            result_code;
  logic [7:0]         event_status, event_data_a, event_data_b;
  logic [COUNT_W-1:0] events_seen, note_on_total, note_off_total, overrun_total;
  logic [FILL_W-1:0]  fill_level;

  // the result stage moves when it is empty or its result is taken;
  // the request stage takes a new request when it is empty or moves on
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !stage_valid || advance;
  assign take     = s_tvalid && s_tready;

  // pointers and counters that depend only on the request
  evq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .advance     (advance),
    .req_type    (s_tuser[0]),
    .header_byte (s_tdata[7:0]),
    .midi_byte0  (s_tdata[15:8]),
    .midi_byte1  (s_tdata[23:16]),
    .midi_byte2  (s_tdata[31:24]),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // event ring; read data holds while the request stage is stalled
  evq_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // note counters need the popped entry, so they live after the ram read
  evq_out u_out (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .stage_valid    (stage_valid),
    .stage          (stage),
    .rd_data        (rd_data),
    .out_valid      (m_tvalid),
    .result_code    (result_code),
    .event_status   (event_status),
    .event_data_a   (event_data_a),
    .event_data_b   (event_data_b),
    .events_seen    (events_seen),
    .note_on_total  (note_on_total),
    .note_off_total (note_off_total),
    .overrun_total  (overrun_total),
    .fill_level     (fill_level)
  );

  assign m_tdata = {fill_level, overrun_total, note_off_total, note_on_total,
                    events_seen, event_data_b, event_data_a, event_status};
  assign m_tuser = result_code;

endmodule

### dv/midi_queue_checker.sv
`timescale 1ns / 1ps
// checker that predicts usb midi event queue results and compares them with the block
module midi_queue_checker import evq_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  input  logic [2:0]   m_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    result_t            rc;
    logic [7:0]         st;
    logic [7:0]         da;
    logic [7:0]         db;
    logic [COUNT_W-1:0] seen;
    logic [COUNT_W-1:0] on;
    logic [COUNT_W-1:0] off;
    logic [COUNT_W-1:0] ovr;
    logic [FILL_W-1:0]  fill;
  } queue_reply_t;

  // predicted ring and counters
  logic [EVENT_W-1:0] ring [DEPTH];
  int unsigned        head;
  int unsigned        tail;
  logic [COUNT_W-1:0] seen_cnt;
  logic [COUNT_W-1:0] on_cnt;
  logic [COUNT_W-1:0] off_cnt;
  logic [COUNT_W-1:0] ovr_cnt;
  queue_reply_t       replies_due [$];

  function automatic int unsigned bytes_carried(input logic [3:0] cin);
    int unsigned n;
    case (cin)
      4'h0:                      n = 0;
      4'h1, 4'h5, 4'hF:          n = 1;
      4'h2, 4'h6, 4'hC, 4'hD:    n = 2;
      default:                   n = 3;
    endcase
    return n;
  endfunction

  task automatic apply_request(input logic pop, input logic [31:0] pkt,
                               output queue_reply_t r);
    logic [7:0]         st;
    logic [7:0]         da;
    logic [7:0]         db;
    logic [EVENT_W-1:0] ent;
    int unsigned        nbytes;
    r = '0;
    if (!pop) begin
      nbytes = bytes_carried(pkt[3:0]);
      st = pkt[15:8];
      da = (nbytes >= 2) ? pkt[23:16] : 8'h00;
      db = (nbytes == 3) ? pkt[31:24] : 8'h00;
      if (nbytes == 0) begin
        r.rc = RC_IGNORED;
      end else begin
        seen_cnt++;
        if ((head + 1) % DEPTH == tail) begin
          ovr_cnt++;
          r.rc = RC_DROPPED;
        end else begin
          ring[head] = {st, da, db};
          head = (head + 1) % DEPTH;
          r.rc = RC_QUEUED;
        end
      end
    end else if (head == tail) begin
      r.rc = RC_EMPTY;
    end else begin
      ent = ring[tail];
      tail = (tail + 1) % DEPTH;
      {r.st, r.da, r.db} = ent;
      if (r.st[7:4] == CMD_NOTE_ON && r.db != 8'h00) on_cnt++;
      else if (r.st[7:4] == CMD_NOTE_ON || r.st[7:4] == CMD_NOTE_OFF) off_cnt++;
      r.rc = RC_POPPED;
    end
    r.seen = seen_cnt;
    r.on   = on_cnt;
    r.off  = off_cnt;
    r.ovr  = ovr_cnt;
    r.fill = FILL_W'((head + DEPTH - tail) % DEPTH);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (rst) begin
      head       = 0;
      tail       = 0;
      seen_cnt   = '0;
      on_cnt     = '0;
      off_cnt    = '0;
      ovr_cnt    = '0;
      fail_count = 0;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("result_code",    32'(want.rc),   32'(m_tuser));
          check_field("event_status",   32'(want.st),   32'(m_tdata[7:0]));
          check_field("event_data_a",   32'(want.da),   32'(m_tdata[15:8]));
          check_field("event_data_b",   32'(want.db),   32'(m_tdata[23:16]));
          check_field("events_seen",    want.seen,      m_tdata[55:24]);
          check_field("note_on_total",  want.on,        m_tdata[87:56]);
          check_field("note_off_total", want.off,       m_tdata[119:88]);
          check_field("overrun_total",  want.ovr,       m_tdata[151:120]);
          check_field("fill_level",     32'(want.fill), 32'(m_tdata[159:152]));
        end
      end
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser[0], s_tdata, want);
        replies_due.push_back(want);
      end
    end
    pending = replies_due.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// testbench top for the usb midi event queue: request stimulus, result stalls, verdict
module tb;
  import evq_pkg::*;

  localparam int unsigned RING_DEPTH    = QUEUE_DEPTH_DEFAULT;
  // random requests sent after the directed ones
  localparam int unsigned RANDOM_EVENTS = 1600;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata  = '0;
  logic [0:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic [2:0]   m_tuser;

  int           fail_count;
  int           pending;
  int unsigned  ready_hold = 0;
  // set per segment: a stretch of back to back requests
  bit           no_gaps = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  usb_midi_event_queue #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  midi_queue_checker #(
    .DEPTH(RING_DEPTH)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // packet with random header and bytes, biased toward note on / note off
  // status bytes and zero velocity
  function automatic logic [31:0] random_packet();
    logic [7:0] st;
    logic [7:0] db;
    st = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) begin
      st[7:4] = ($urandom_range(0, 1) == 1) ? CMD_NOTE_ON : CMD_NOTE_OFF;
    end
    db = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    return {db, 8'($urandom_range(0, 255)), st, 8'($urandom_range(0, 255))};
  endfunction

  // one request: optional idle gap, then hold valid until taken
  task automatic send_request(input logic pop, input logic [31:0] pkt);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= pop;
    s_tdata  <= pkt;
    do @(posedge clk); while (!s_tready);
  endtask

  // result side: alternate ready stretches and stalls of random length
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (m_tready) begin
      m_tready   <= 1'b0;
      ready_hold <= idle_len();
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(0, 12);
    end
  end

  initial begin
    int unsigned counted;
    int unsigned seg_len;
    int unsigned push_pct;
    logic [31:0] pkt;
    logic        pop;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // pop on an empty queue
    send_request(1'b1, 32'hFFFF_FFFF);
    // every code index with extreme bytes; code 0 is ignored, single and
    // double byte codes must zero the unused bytes, cable nibble alternates
    for (int c = 0; c < 16; c++) begin
      pkt = {(c[1] ? 8'h00 : 8'hFF), 8'hFF, (c[0] ? 8'h9F : 8'h80),
             (c[1] ? 4'hF : 4'h0), 4'(c)};
      send_request(1'b0, pkt);
    end
    // drain part of it: note on, note off and zero velocity note on
    repeat (10) send_request(1'b1, 32'h0000_0000);

    // random segments: floods that fill the ring and overrun, mixed
    // traffic, and drains that run into the empty case
    counted = 0;
    while (counted < RANDOM_EVENTS) begin
      case ($urandom_range(0, 2))
        0: begin
          push_pct = 97;
          seg_len  = $urandom_range(260, 400);
        end
        1: begin
          push_pct = 50;
          seg_len  = $urandom_range(10, 300);
        end
        default: begin
          push_pct = 10;
          seg_len  = $urandom_range(10, 300);
        end
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        if (counted < RANDOM_EVENTS) begin
          pop = ($urandom_range(0, 99) >= push_pct);
          pkt = random_packet();
          send_request(pop, pkt);
          counted++;
        end
      end
    end
    s_tvalid <= 1'b0;

    // wait for every outstanding result, then for any stray results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
